// File: rtl/core/rtsjs_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package rtsjs_pkg;

    localparam int ID_W          = 16;
    localparam int PRICE_W       = 24;
    localparam int KEY_W         = 24;
    localparam int REQ_W         = 2;
    localparam int STATUS_W      = 2;
    localparam int INDEX_OUT_W   = 7;
    localparam int COUNT_OUT_W   = 8;

    localparam logic [REQ_W-1:0] REQ_INSERT     = 2'd0;
    localparam logic [REQ_W-1:0] REQ_FIND       = 2'd1;
    localparam logic [REQ_W-1:0] REQ_SORT_PRICE = 2'd2;

    localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
    localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 2'd1;
    localparam logic [STATUS_W-1:0] ST_FULL      = 2'd2;

    typedef struct packed {
        logic [ID_W-1:0]    id;
        logic [PRICE_W-1:0] price;
    } record_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_SORT_START,
        S_SORT_SCAN,
        S_SWAP_LO,
        S_SWAP_HI,
        S_SORT_END,
        S_SQRT_WAIT,
        S_JUMP_ISSUE,
        S_JUMP_CHECK,
        S_LIN_ISSUE,
        S_LIN_CHECK,
        S_DONE
    } state_t;

endpackage

`default_nettype wire

// File: rtl/core/rtsjs_if.sv
`timescale 1ns / 1ps
`default_nettype none

interface rtsjs_req_if;
    import rtsjs_pkg::*;

    logic                valid;
    logic                ready;
    logic [REQ_W-1:0]    req_type;
    logic [ID_W-1:0]     train_id;
    logic [PRICE_W-1:0]  price_in;

    modport source (output valid, output req_type, output train_id, output price_in,
                    input ready);
    modport sink   (input valid, input req_type, input train_id, input price_in,
                    output ready);
endinterface

interface rtsjs_rsp_if;
    import rtsjs_pkg::*;

    logic                   valid;
    logic                   ready;
    logic [STATUS_W-1:0]    status;
    logic [INDEX_OUT_W-1:0] found_index;
    logic [PRICE_W-1:0]     found_price;
    logic [COUNT_OUT_W-1:0] record_count;

    modport source (output valid, output status, output found_index, output found_price,
                    output record_count, input ready);
    modport sink   (input valid, input status, input found_index, input found_price,
                    input record_count, output ready);
endinterface

`default_nettype wire

// File: rtl/core/rtsjs_isqrt.sv
`timescale 1ns / 1ps
`default_nettype none

// Integer square root by counting up: the next square is formed with one add per cycle.
module rtsjs_isqrt #(
    parameter int VALUE_W = 8
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  logic [VALUE_W-1:0] value,
    output logic               done,
    output logic [VALUE_W-1:0] root
);

    logic               busy_reg, busy_next;
    logic               done_reg, done_next;
    logic [VALUE_W-1:0] value_reg, value_next;
    logic [VALUE_W-1:0] root_reg, root_next;
    logic [VALUE_W:0]   sq_reg, sq_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        value_reg <= value_next;
        root_reg  <= root_next;
        sq_reg    <= sq_next;
    end

    always_comb
    begin
        busy_next  = busy_reg;
        done_next  = 1'b0;
        value_next = value_reg;
        root_next  = root_reg;
        sq_next    = sq_reg;
        if (start)
        begin
            busy_next  = 1'b1;
            value_next = value;
            root_next  = '0;
            sq_next    = (VALUE_W+1)'(1);
        end
        else if (busy_reg)
        begin
            // sq_reg holds (root + 1) squared.
            if (sq_reg <= {1'b0, value_reg})
            begin
                root_next = root_reg + VALUE_W'(1);
                sq_next   = sq_reg + {root_reg, 1'b0} + (VALUE_W+1)'(3);
            end
            else
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    assign done = done_reg;
    assign root = root_reg;

endmodule

`default_nettype wire

// File: rtl/core/record_table_sort_and_jump_search.sv
// Insert and unused request codes: idle, then done, which loads the result registers.
// Sort by price over n records: a selection sort that scans the table memory through
// its one read port, one record per cycle for each row of the sort.
// Find: the same sort by id, then an integer square root of n as the jump size, then
// jump search and linear search. One transaction is worked at a time.
// Reset clears the record count; the table contents stay undefined and are never used.
`timescale 1ns / 1ps
`default_nettype none

module record_table_sort_and_jump_search #(
    parameter int TABLE_DEPTH = 128
) (
    input  logic        clk,
    input  logic        rst_n,
    rtsjs_req_if.sink   req,
    rtsjs_rsp_if.source rsp
);
    import rtsjs_pkg::*;

    localparam int IDX_W = $clog2(TABLE_DEPTH);
    localparam int CNT_W = $clog2(TABLE_DEPTH + 1);
    localparam int POS_W = CNT_W + 1;
    localparam logic [CNT_W-1:0] DEPTH_C = CNT_W'(TABLE_DEPTH);

    state_t state_reg, state_next;

    logic [CNT_W-1:0]       count_reg, count_next;
    logic                   sort_price_reg, sort_price_next;
    logic [ID_W-1:0]        target_reg, target_next;
    logic [IDX_W-1:0]       i_reg, i_next;
    logic [CNT_W-1:0]       j_reg, j_next;
    logic                   first_reg, first_next;
    logic [IDX_W-1:0]       best_idx_reg, best_idx_next;
    record_t                best_rec_reg, best_rec_next;
    record_t                head_rec_reg, head_rec_next;
    logic [CNT_W-1:0]       jump_reg, jump_next;
    logic [POS_W-1:0]       step_reg, step_next;
    logic [POS_W-1:0]       prev_reg, prev_next;
    logic [STATUS_W-1:0]    res_status_reg, res_status_next;
    logic [IDX_W-1:0]       res_pos_reg, res_pos_next;
    logic [PRICE_W-1:0]     res_price_reg, res_price_next;

    logic                   rsp_valid_reg, rsp_valid_next;
    logic [STATUS_W-1:0]    out_status_reg, out_status_next;
    logic [INDEX_OUT_W-1:0] out_index_reg, out_index_next;
    logic [PRICE_W-1:0]     out_price_reg, out_price_next;
    logic [COUNT_OUT_W-1:0] out_count_reg, out_count_next;

    record_t                table_mem [TABLE_DEPTH];
    record_t                rd_data_reg;
    logic [IDX_W-1:0]       rd_addr;
    logic                   wr_en;
    logic [IDX_W-1:0]       wr_addr;
    record_t                wr_data;

    logic [KEY_W-1:0]       cmp_a, cmp_b;
    logic                   cmp_lt;
    logic                   cmp_eq;

    logic                   sqrt_start;
    logic                   sqrt_done;
    logic [CNT_W-1:0]       sqrt_root;

    logic [KEY_W-1:0]       rd_key;
    logic [KEY_W-1:0]       best_key;
    logic [POS_W-1:0]       count_wide;
    logic [POS_W-1:0]       lim;
    logic [POS_W-1:0]       lim_m1;
    logic [CNT_W-1:0]       j_prev;
    logic [31:0]            pos_wide;
    logic [31:0]            count_out_wide;

    rtsjs_isqrt #(
        .VALUE_W (CNT_W)
    ) u_isqrt (
        .clk   (clk),
        .rst_n (rst_n),
        .start (sqrt_start),
        .value (count_reg),
        .done  (sqrt_done),
        .root  (sqrt_root)
    );

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            table_mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= table_mem[rd_addr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        sort_price_reg <= sort_price_next;
        target_reg     <= target_next;
        i_reg          <= i_next;
        j_reg          <= j_next;
        first_reg      <= first_next;
        best_idx_reg   <= best_idx_next;
        best_rec_reg   <= best_rec_next;
        head_rec_reg   <= head_rec_next;
        jump_reg       <= jump_next;
        step_reg       <= step_next;
        prev_reg       <= prev_next;
        res_status_reg <= res_status_next;
        res_pos_reg    <= res_pos_next;
        res_price_reg  <= res_price_next;
        out_status_reg <= out_status_next;
        out_index_reg  <= out_index_next;
        out_price_reg  <= out_price_next;
        out_count_reg  <= out_count_next;
    end

    assign rd_key   = sort_price_reg ? rd_data_reg.price : KEY_W'(rd_data_reg.id);
    assign best_key = sort_price_reg ? best_rec_reg.price : KEY_W'(best_rec_reg.id);

    // The one less-than comparator on keys, shared by the sort scan and the jump steps.
    assign cmp_lt = cmp_a < cmp_b;
    assign cmp_eq = rd_data_reg.id == target_reg;

    assign count_wide     = POS_W'(count_reg);
    assign lim            = (step_reg < count_wide) ? step_reg : count_wide;
    assign lim_m1         = lim - POS_W'(1);
    assign j_prev         = j_reg - CNT_W'(1);
    assign pos_wide       = 32'(res_pos_reg);
    assign count_out_wide = 32'(count_reg);

    always_comb
    begin
        state_next      = state_reg;
        count_next      = count_reg;
        sort_price_next = sort_price_reg;
        target_next     = target_reg;
        i_next          = i_reg;
        j_next          = j_reg;
        first_next      = first_reg;
        best_idx_next   = best_idx_reg;
        best_rec_next   = best_rec_reg;
        head_rec_next   = head_rec_reg;
        jump_next       = jump_reg;
        step_next       = step_reg;
        prev_next       = prev_reg;
        res_status_next = res_status_reg;
        res_pos_next    = res_pos_reg;
        res_price_next  = res_price_reg;
        rsp_valid_next  = rsp_valid_reg && !rsp.ready;
        out_status_next = out_status_reg;
        out_index_next  = out_index_reg;
        out_price_next  = out_price_reg;
        out_count_next  = out_count_reg;
        rd_addr         = i_reg;
        wr_en           = 1'b0;
        wr_addr         = i_reg;
        wr_data         = best_rec_reg;
        cmp_a           = rd_key;
        cmp_b           = best_key;
        sqrt_start      = 1'b0;

        case (state_reg)
            S_IDLE:
            begin
                if (req.valid)
                begin
                    target_next     = req.train_id;
                    sort_price_next = (req.req_type == REQ_SORT_PRICE);
                    res_status_next = ST_OK;
                    res_pos_next    = '0;
                    res_price_next  = '0;
                    i_next          = '0;
                    state_next      = S_DONE;
                    if (req.req_type == REQ_INSERT)
                    begin
                        if (count_reg >= DEPTH_C)
                        begin
                            res_status_next = ST_FULL;
                        end
                        else
                        begin
                            wr_en      = 1'b1;
                            wr_addr    = count_reg[IDX_W-1:0];
                            wr_data    = '{id: req.train_id, price: req.price_in};
                            count_next = count_reg + CNT_W'(1);
                        end
                    end
                    else if (req.req_type == REQ_FIND || req.req_type == REQ_SORT_PRICE)
                    begin
                        if (count_reg >= CNT_W'(2))
                        begin
                            state_next = S_SORT_START;
                        end
                        else
                        begin
                            state_next = S_SORT_END;
                        end
                    end
                end
            end

            S_SORT_START:
            begin
                rd_addr    = i_reg;
                j_next     = CNT_W'(i_reg) + CNT_W'(1);
                first_next = 1'b1;
                state_next = S_SORT_SCAN;
            end

            S_SORT_SCAN:
            begin
                // The read data belongs to the address issued in the previous cycle, j - 1.
                rd_addr    = j_reg[IDX_W-1:0];
                first_next = 1'b0;
                if (first_reg)
                begin
                    best_rec_next = rd_data_reg;
                    head_rec_next = rd_data_reg;
                    best_idx_next = i_reg;
                    j_next        = j_reg + CNT_W'(1);
                end
                else
                begin
                    if (cmp_lt)
                    begin
                        best_rec_next = rd_data_reg;
                        best_idx_next = j_prev[IDX_W-1:0];
                    end
                    if (j_reg == count_reg)
                    begin
                        state_next = S_SWAP_LO;
                    end
                    else
                    begin
                        j_next = j_reg + CNT_W'(1);
                    end
                end
            end

            S_SWAP_LO:
            begin
                if (best_idx_reg != i_reg)
                begin
                    wr_en      = 1'b1;
                    wr_addr    = i_reg;
                    wr_data    = best_rec_reg;
                    state_next = S_SWAP_HI;
                end
                else if (POS_W'(i_reg) + POS_W'(2) < count_wide)
                begin
                    i_next     = i_reg + IDX_W'(1);
                    state_next = S_SORT_START;
                end
                else
                begin
                    state_next = S_SORT_END;
                end
            end

            S_SWAP_HI:
            begin
                wr_en   = 1'b1;
                wr_addr = best_idx_reg;
                wr_data = head_rec_reg;
                if (POS_W'(i_reg) + POS_W'(2) < count_wide)
                begin
                    i_next     = i_reg + IDX_W'(1);
                    state_next = S_SORT_START;
                end
                else
                begin
                    state_next = S_SORT_END;
                end
            end

            S_SORT_END:
            begin
                if (sort_price_reg)
                begin
                    state_next = S_DONE;
                end
                else if (count_reg == '0)
                begin
                    res_status_next = ST_NOT_FOUND;
                    state_next      = S_DONE;
                end
                else
                begin
                    sqrt_start = 1'b1;
                    state_next = S_SQRT_WAIT;
                end
            end

            S_SQRT_WAIT:
            begin
                if (sqrt_done)
                begin
                    jump_next  = sqrt_root;
                    step_next  = POS_W'(sqrt_root);
                    prev_next  = '0;
                    state_next = S_JUMP_ISSUE;
                end
            end

            S_JUMP_ISSUE:
            begin
                rd_addr    = lim_m1[IDX_W-1:0];
                state_next = S_JUMP_CHECK;
            end

            S_JUMP_CHECK:
            begin
                cmp_a = KEY_W'(rd_data_reg.id);
                cmp_b = KEY_W'(target_reg);
                if (!cmp_lt)
                begin
                    state_next = S_LIN_ISSUE;
                end
                else
                begin
                    prev_next = step_reg;
                    step_next = step_reg + POS_W'(jump_reg);
                    if (step_reg >= count_wide)
                    begin
                        state_next = S_LIN_ISSUE;
                    end
                    else
                    begin
                        state_next = S_JUMP_ISSUE;
                    end
                end
            end

            S_LIN_ISSUE:
            begin
                rd_addr = prev_reg[IDX_W-1:0];
                if (prev_reg >= lim)
                begin
                    res_status_next = ST_NOT_FOUND;
                    state_next      = S_DONE;
                end
                else
                begin
                    state_next = S_LIN_CHECK;
                end
            end

            S_LIN_CHECK:
            begin
                if (cmp_eq)
                begin
                    res_pos_next   = prev_reg[IDX_W-1:0];
                    res_price_next = rd_data_reg.price;
                    state_next     = S_DONE;
                end
                else
                begin
                    prev_next  = prev_reg + POS_W'(1);
                    state_next = S_LIN_ISSUE;
                end
            end

            S_DONE:
            begin
                if (!rsp_valid_reg || rsp.ready)
                begin
                    rsp_valid_next  = 1'b1;
                    out_status_next = res_status_reg;
                    out_index_next  = pos_wide[INDEX_OUT_W-1:0];
                    out_price_next  = res_price_reg;
                    out_count_next  = count_out_wide[COUNT_OUT_W-1:0];
                    state_next      = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign req.ready        = (state_reg == S_IDLE);
    assign rsp.valid        = rsp_valid_reg;
    assign rsp.status       = out_status_reg;
    assign rsp.found_index  = out_index_reg;
    assign rsp.found_price  = out_price_reg;
    assign rsp.record_count = out_count_reg;

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= DEPTH_C)
        else $error("Record count is above the table depth.");

    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        req.valid && req.ready |=> !req.ready)
        else $error("A transaction was accepted while the previous one was still at work.");

    a_full_only_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        rsp.valid && rsp.status == ST_FULL |-> count_reg == DEPTH_C)
        else $error("Table full was reported while the table had room.");

    a_not_found_zero: assert property (@(posedge clk) disable iff (!rst_n)
        rsp.valid && rsp.status == ST_NOT_FOUND |-> rsp.found_price == '0 && rsp.found_index == '0)
        else $error("A failed search returned a record.");

    a_swap_order: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_SWAP_HI |-> best_idx_reg > i_reg && $past(state_reg) == S_SWAP_LO)
        else $error("A swap was made towards an earlier position.");

endmodule

`default_nettype wire

// File: tb/sv/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
    import rtsjs_pkg::*;

    localparam int TABLE_DEPTH = 128;
    localparam int CYCLE_LIMIT = 3_000_000;
    localparam int SETTLE_CYCLES = 20;
    localparam int REPORT_LIMIT = 10;
    localparam logic [REQ_W-1:0] REQ_UNUSED = 2'd3;

    typedef struct {
        logic [STATUS_W-1:0]    status;
        logic [INDEX_OUT_W-1:0] index;
        logic [PRICE_W-1:0]     price;
        logic [COUNT_OUT_W-1:0] count;
    } answer_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    rtsjs_req_if req_bus ();
    rtsjs_rsp_if rsp_bus ();

    record_table_sort_and_jump_search #(
        .TABLE_DEPTH(TABLE_DEPTH)
    ) DUT (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_bus),
        .rsp   (rsp_bus)
    );

    bit [ID_W-1:0]    id_table [TABLE_DEPTH];
    bit [PRICE_W-1:0] price_table [TABLE_DEPTH];
    int unsigned      table_fill;

    answer_t     pending_answers[$];
    int unsigned mismatch_count;
    int unsigned answers_checked;
    int unsigned requests_sent [4];
    int unsigned hits_seen;
    int unsigned full_seen;
    int unsigned cycle_count;
    int unsigned long_hold_cycles;
    bit          no_idle;

    always #2 clk = ~clk;

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("[record_table_sort_and_jump_search] ERROR");
            $finish;
        end
    end

    function automatic int unsigned pick_gap();
        int unsigned roll;
        if (no_idle)
        begin
            return 0;
        end
        roll = $urandom_range(0, 99);
        if (roll < 55)
        begin
            return 0;
        end
        if (roll < 92)
        begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(10, 60);
    endfunction

    function automatic logic [ID_W-1:0] random_id();
        if ($urandom_range(0, 3) == 0)
        begin
            return ID_W'($urandom_range(0, 15));
        end
        return ID_W'($urandom);
    endfunction

    function automatic logic [PRICE_W-1:0] random_price();
        if ($urandom_range(0, 3) == 0)
        begin
            return PRICE_W'($urandom_range(0, 7));
        end
        return PRICE_W'($urandom);
    endfunction

    function automatic bit [KEY_W-1:0] row_key(input int unsigned row, input bit by_price);
        if (by_price)
        begin
            return price_table[row];
        end
        return {{(KEY_W - ID_W){1'b0}}, id_table[row]};
    endfunction

    function automatic void swap_rows(input int unsigned a, input int unsigned b);
        bit [ID_W-1:0]    id_keep;
        bit [PRICE_W-1:0] price_keep;
        id_keep        = id_table[a];
        price_keep     = price_table[a];
        id_table[a]    = id_table[b];
        price_table[a] = price_table[b];
        id_table[b]    = id_keep;
        price_table[b] = price_keep;
    endfunction

    // The first strict minimum is chosen, so equal keys keep no particular order.
    function automatic void order_rows(input bit by_price);
        int unsigned row;
        int unsigned probe;
        int unsigned least;
        for (row = 0; row + 1 < table_fill; row++)
        begin
            least = row;
            for (probe = row + 1; probe < table_fill; probe++)
            begin
                if (row_key(probe, by_price) < row_key(least, by_price))
                begin
                    least = probe;
                end
            end
            if (least != row)
            begin
                swap_rows(row, least);
            end
        end
    endfunction

    function automatic int unsigned int_sqrt(input int unsigned v);
        int unsigned root;
        root = 0;
        while ((root + 1) * (root + 1) <= v)
        begin
            root++;
        end
        return root;
    endfunction

    function automatic bit jump_search(input bit [ID_W-1:0] target, output int unsigned pos);
        int unsigned stride;
        int unsigned block_end;
        int unsigned start;
        int unsigned lim;
        stride    = int_sqrt(table_fill);
        block_end = stride;
        start     = 0;
        pos       = 0;
        while (start < table_fill)
        begin
            lim = (block_end < table_fill) ? block_end : table_fill;
            if (lim == 0)
            begin
                break;
            end
            if (id_table[lim - 1] >= target)
            begin
                break;
            end
            start = block_end;
            block_end += stride;
            if (start >= table_fill)
            begin
                break;
            end
        end
        lim = (block_end < table_fill) ? block_end : table_fill;
        while (start < lim)
        begin
            if (id_table[start] == target)
            begin
                pos = start;
                return 1'b1;
            end
            start++;
        end
        return 1'b0;
    endfunction

    function automatic answer_t predict_answer(input logic [REQ_W-1:0] kind,
                                               input logic [ID_W-1:0] id,
                                               input logic [PRICE_W-1:0] price);
        answer_t     ans;
        int unsigned hit_pos;
        ans.status = ST_OK;
        ans.index  = '0;
        ans.price  = '0;
        case (kind)
            REQ_INSERT:
            begin
                if (table_fill >= TABLE_DEPTH)
                begin
                    ans.status = ST_FULL;
                end
                else
                begin
                    id_table[table_fill]    = id;
                    price_table[table_fill] = price;
                    table_fill++;
                end
            end
            REQ_FIND:
            begin
                order_rows(1'b0);
                if (jump_search(id, hit_pos))
                begin
                    ans.index = INDEX_OUT_W'(hit_pos);
                    ans.price = price_table[hit_pos];
                end
                else
                begin
                    ans.status = ST_NOT_FOUND;
                end
            end
            REQ_SORT_PRICE:
            begin
                order_rows(1'b1);
            end
            default:
            begin
            end
        endcase
        ans.count = COUNT_OUT_W'(table_fill);
        return ans;
    endfunction

    task automatic send_request(input logic [REQ_W-1:0] kind,
                                input logic [ID_W-1:0] id,
                                input logic [PRICE_W-1:0] price);
        int unsigned gap;
        answer_t     ans;
        gap = pick_gap();
        if (gap > 0)
        begin
            req_bus.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req_bus.valid    <= 1'b1;
        req_bus.req_type <= kind;
        req_bus.train_id <= id;
        req_bus.price_in <= price;
        @(posedge clk);
        while (!req_bus.ready)
        begin
            @(posedge clk);
        end
        ans = predict_answer(kind, id, price);
        pending_answers.push_back(ans);
        requests_sent[kind]++;
    endtask

    task automatic wait_drained();
        req_bus.valid <= 1'b0;
        do
        begin
            @(posedge clk);
        end
        while (pending_answers.size() != 0);
    endtask

    task automatic report_mismatch(input string what);
        mismatch_count++;
        if (mismatch_count <= REPORT_LIMIT)
        begin
            $display("mismatch at cycle %0d: %s", cycle_count, what);
        end
    endtask

    task automatic check_answer();
        answer_t want;
        if (pending_answers.size() == 0)
        begin
            report_mismatch($sformatf("result with no transaction pending: status %0d",
                                      rsp_bus.status));
        end
        else
        begin
            want = pending_answers.pop_front();
            answers_checked++;
            if (rsp_bus.status == ST_OK && want.status == ST_OK && want.price != 0)
            begin
                hits_seen++;
            end
            if (want.status == ST_FULL)
            begin
                full_seen++;
            end
            if (rsp_bus.status !== want.status)
            begin
                report_mismatch($sformatf("status expected %0d got %0d",
                                          want.status, rsp_bus.status));
            end
            if (rsp_bus.found_index !== want.index)
            begin
                report_mismatch($sformatf("found_index expected %0d got %0d",
                                          want.index, rsp_bus.found_index));
            end
            if (rsp_bus.found_price !== want.price)
            begin
                report_mismatch($sformatf("found_price expected %06h got %06h",
                                          want.price, rsp_bus.found_price));
            end
            if (rsp_bus.record_count !== want.count)
            begin
                report_mismatch($sformatf("record_count expected %0d got %0d",
                                          want.count, rsp_bus.record_count));
            end
        end
    endtask

    always @(posedge clk)
    begin
        if (rst_n && rsp_bus.valid && rsp_bus.ready)
        begin
            check_answer();
        end
    end

    initial
    begin : result_ready_driver
        int unsigned run;
        run = 0;
        rsp_bus.ready <= 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            @(posedge clk);
            if (long_hold_cycles > 0)
            begin
                rsp_bus.ready <= 1'b0;
                long_hold_cycles--;
                run = 0;
            end
            else if (run > 0)
            begin
                run--;
            end
            else if (no_idle || $urandom_range(0, 3) != 0)
            begin
                rsp_bus.ready <= 1'b1;
                run = $urandom_range(0, 7);
            end
            else
            begin
                rsp_bus.ready <= 1'b0;
                run = pick_gap();
            end
        end
    end

    task automatic test_directed();
        send_request(REQ_FIND, 16'h0000, 24'h000000);
        send_request(REQ_SORT_PRICE, 16'h0000, 24'h000000);
        send_request(REQ_UNUSED, 16'hFFFF, 24'hFFFFFF);
        send_request(REQ_INSERT, 16'hFFFF, 24'hFFFFFF);
        send_request(REQ_FIND, 16'h0001, 24'h000000);
        send_request(REQ_FIND, 16'hFFFF, 24'h000000);
        send_request(REQ_INSERT, 16'h0000, 24'h000000);
        send_request(REQ_INSERT, 16'h1234, 24'h000100);
        send_request(REQ_INSERT, 16'h1234, 24'h800000);
        send_request(REQ_INSERT, 16'h8000, 24'h000100);
        send_request(REQ_INSERT, 16'h7FFF, 24'h7FFFFF);
        send_request(REQ_FIND, 16'hFFFF, 24'hFFFFFF);
        send_request(REQ_FIND, 16'h0000, 24'h000000);
        send_request(REQ_FIND, 16'h1234, 24'h000000);
        send_request(REQ_FIND, 16'h1235, 24'h000000);
        send_request(REQ_FIND, 16'h7FFE, 24'h000000);
        send_request(REQ_SORT_PRICE, 16'hAAAA, 24'h555555);
        send_request(REQ_FIND, 16'h8000, 24'h000000);
        send_request(REQ_UNUSED, 16'h0000, 24'h000000);
        send_request(REQ_FIND, 16'h7FFF, 24'h000000);
        wait_drained();
    endtask

    // The result side is held off while transactions keep coming, so the block
    // fills and has to stall its input.
    task automatic test_pressure();
        int i;
        long_hold_cycles = 400;
        for (i = 0; i < 8; i++)
        begin
            if (i == 5)
            begin
                send_request(REQ_FIND, id_table[0], random_price());
            end
            else
            begin
                send_request(REQ_INSERT, random_id(), random_price());
            end
        end
        wait_drained();
    endtask

    task automatic test_random();
        int i;
        int unsigned roll;
        logic [ID_W-1:0] target;
        for (i = 0; i < 100; i++)
        begin
            no_idle = (i >= 40 && i < 60);
            roll = $urandom_range(0, 99);
            if (roll < 45)
            begin
                send_request(REQ_INSERT, random_id(), random_price());
            end
            else if (roll < 90)
            begin
                target = random_id();
                if (table_fill > 0 && $urandom_range(0, 9) < 7)
                begin
                    target = id_table[$urandom_range(0, table_fill - 1)];
                end
                send_request(REQ_FIND, target, random_price());
            end
            else if (roll < 97)
            begin
                send_request(REQ_SORT_PRICE, random_id(), random_price());
            end
            else
            begin
                send_request(REQ_UNUSED, random_id(), random_price());
            end
        end
        no_idle = 1'b0;
        wait_drained();
    endtask

    task automatic test_capacity();
        int i;
        while (table_fill < TABLE_DEPTH)
        begin
            no_idle = (table_fill % 32) < 16;
            send_request(REQ_INSERT, random_id(), random_price());
        end
        no_idle = 1'b0;
        send_request(REQ_INSERT, 16'hFFFF, 24'hFFFFFF);
        send_request(REQ_INSERT, 16'h0000, 24'h000000);
        send_request(REQ_FIND, id_table[TABLE_DEPTH - 1], 24'h000000);
        send_request(REQ_FIND, random_id(), 24'h000000);
        send_request(REQ_SORT_PRICE, 16'h0000, 24'h000000);
        send_request(REQ_FIND, id_table[$urandom_range(0, TABLE_DEPTH - 1)], 24'hFFFFFF);
        send_request(REQ_UNUSED, random_id(), random_price());
        send_request(REQ_INSERT, random_id(), random_price());
        for (i = 0; i < 3; i++)
        begin
            send_request(REQ_FIND, id_table[$urandom_range(0, TABLE_DEPTH - 1)],
                         random_price());
        end
        wait_drained();
    endtask

    initial
    begin
        req_bus.valid    <= 1'b0;
        req_bus.req_type <= REQ_INSERT;
        req_bus.train_id <= '0;
        req_bus.price_in <= '0;
        table_fill       = 0;
        mismatch_count   = 0;
        answers_checked  = 0;
        hits_seen        = 0;
        full_seen        = 0;
        cycle_count      = 0;
        long_hold_cycles = 0;
        no_idle          = 1'b0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed();
        test_pressure();
        test_random();
        test_capacity();

        wait_drained();
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (pending_answers.size() != 0)
        begin
            report_mismatch("transactions left without a result");
        end
        $display("Checked %0d results: %0d inserts, %0d finds, %0d price sorts, %0d unused codes.",
                 answers_checked, requests_sent[REQ_INSERT], requests_sent[REQ_FIND],
                 requests_sent[REQ_SORT_PRICE], requests_sent[REQ_UNUSED]);
        $display("Finds with a priced hit: %0d, full-table rejections: %0d, mismatches: %0d.",
                 hits_seen, full_seen, mismatch_count);
        if (mismatch_count == 0)
        begin
            $display("[record_table_sort_and_jump_search] OK");
        end
        else
        begin
            $display("[record_table_sort_and_jump_search] ERROR");
        end
        $finish;
    end

endmodule
